// File: rtl/core/kps_pkg.sv
`timescale 1ns / 1ps

package kps_pkg;

  localparam int unsigned RowCount    = 4;
  localparam int unsigned ColumnCount = 4;
  localparam int unsigned RowW        = $clog2(RowCount);
  localparam int unsigned ColW        = $clog2(ColumnCount);
  localparam int unsigned TickW       = 8;
  localparam int unsigned CodeW       = 7;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [TickW-1:0] SettleReset   = 8'd10;
  localparam logic [TickW-1:0] DebounceReset = 8'd20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETTLE_TICKS   = 1'b0,
    CFG_DEBOUNCE_TICKS = 1'b1
  } kps_cfg_e;

  typedef enum logic [2:0] {
    PH_BTN_CHECK    = 3'd0,
    PH_BTN_DEBOUNCE = 3'd1,
    PH_BTN_RELEASE  = 3'd2,
    PH_SETTLE       = 3'd3,
    PH_KEY_DEBOUNCE = 3'd4,
    PH_KEY_RELEASE  = 3'd5
  } kps_phase_e;

  typedef struct packed {
    logic [ColumnCount-1:0] column_levels;
    logic                   button_level;
  } kps_in_t;

  typedef struct packed {
    logic [RowCount-1:0] row_drive;
    logic                key_valid;
    logic [CodeW-1:0]    key_code;
    logic                page_led;
  } kps_out_t;

  // Keymap, indexed by {page, row, column}
  localparam logic [CodeW-1:0] KeyMap [2*RowCount*ColumnCount] = '{
    7'h41, 7'h42, 7'h43, 7'h44,   // A B C D
    7'h45, 7'h46, 7'h47, 7'h2D,   // E F G -
    7'h48, 7'h49, 7'h4A, 7'h2F,   // H I J /
    7'h4B, 7'h4C, 7'h4D, 7'h2A,   // K L M *
    7'h4E, 7'h4F, 7'h50, 7'h51,   // N O P Q
    7'h52, 7'h53, 7'h54, 7'h20,   // R S T space
    7'h55, 7'h56, 7'h57, 7'h2F,   // U V W /
    7'h58, 7'h59, 7'h5A, 7'h2A    // X Y Z *
  };

  typedef struct packed {
    logic            found;
    logic [ColW-1:0] idx;
  } kps_hit_t;

  // First low column at or above 'from'
  function automatic kps_hit_t first_low(input logic [ColumnCount-1:0] levels,
                                         input logic [ColW:0] from);
    kps_hit_t hit;
    hit = '0;
    for (int j = ColumnCount - 1; j >= 0; j--) begin
      if ((j >= int'(from)) && !levels[j]) begin
        hit.found = 1'b1;
        hit.idx   = ColW'(j);
      end
    end
    return hit;
  endfunction

endpackage

// File: rtl/core/kps_out_buf.sv
`timescale 1ns / 1ps

module kps_out_buf
  import kps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  kps_out_t push_data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kps_out_t out_data_o
);

  kps_out_t   ent0_q, ent1_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = ent0_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Head entry shifts up on pop; new transaction lands behind what stays
  always_ff @(posedge clk_i) begin
    if (pop) begin
      ent0_q <= ent1_q;
    end
    if (push_i) begin
      if (cnt_q == 2'd0 || (pop && cnt_q == 2'd1)) begin
        ent0_q <= push_data_i;
      end else begin
        ent1_q <= push_data_i;
      end
    end
  end

endmodule

// File: rtl/core/matrix_keypad_scanner.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (kps_in_t: one tick)
// out       output     out_valid_o / out_ready_i out_data_o (kps_out_t: one result)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Each accepted tick updates the scan state in the same cycle and yields one result
// in the output buffer, so it takes one transaction per cycle while in_ready_o is high.
// The rate is set by the single state update and the two-entry output buffer.
// Reset (rst_ni low, asynchronous): button check, page 0, all rows high,
// settle 10 ticks, debounce 20 ticks, output buffer empty.
// With the output stalled, up to two results are held; in_ready_o drops only when both
// entries are taken.

module matrix_keypad_scanner
  import kps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kps_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kps_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [TickW-1:0] settle_q, debounce_q;

  // Scan state
  kps_phase_e          phase_q, phase_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [TickW-1:0]    wait_q, wait_d;
  logic                page_q, page_d;
  logic [RowCount-1:0] pattern_q, pattern_d;

  logic     accept;
  logic     buf_full;
  kps_out_t result;

  // Combinational step helpers
  logic            col_low;
  logic            btn_low;
  logic            scan;
  logic [ColW:0]   scan_from;
  kps_hit_t        hit;
  logic            start_row;
  logic [RowW-1:0] start_idx;
  logic            key_valid;
  logic [CodeW-1:0] key_code;

  assign in_ready_o = !buf_full;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration writes: no wait, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= SettleReset;
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      unique case (kps_cfg_e'(cfg_idx_i))
        CFG_SETTLE_TICKS:   settle_q   <= cfg_data_i;
        CFG_DEBOUNCE_TICKS: debounce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign col_low   = !in_data_i.column_levels[col_q];
  assign btn_low   = !in_data_i.button_level;
  assign hit       = first_low(in_data_i.column_levels, scan_from);

  // Next scan state for this tick
  always_comb begin
    phase_d   = phase_q;
    row_d     = row_q;
    col_d     = col_q;
    wait_d    = wait_q;
    page_d    = page_q;
    pattern_d = pattern_q;
    scan      = 1'b0;
    scan_from = '0;
    start_row = 1'b0;
    start_idx = '0;
    key_valid = 1'b0;
    key_code  = '0;

    unique case (phase_q)
      PH_BTN_DEBOUNCE: begin
        if (wait_q != '0) begin
          wait_d = wait_q - 1'b1;
        end else if (btn_low) begin
          phase_d = PH_BTN_RELEASE;
        end else begin
          start_row = 1'b1;
        end
      end
      PH_BTN_RELEASE: begin
        // Toggle the page once the button is let go
        if (!btn_low) begin
          page_d    = !page_q;
          start_row = 1'b1;
        end
      end
      PH_SETTLE: begin
        if (wait_q != '0) begin
          wait_d = wait_q - 1'b1;
        end else begin
          scan = 1'b1;
        end
      end
      PH_KEY_DEBOUNCE: begin
        if (wait_q != '0) begin
          wait_d = wait_q - 1'b1;
        end else if (col_low) begin
          phase_d = PH_KEY_RELEASE;
        end else begin
          // Failed recheck: try the remaining columns on this same tick
          scan      = 1'b1;
          scan_from = {1'b0, col_q} + 1'b1;
        end
      end
      PH_KEY_RELEASE: begin
        if (!col_low) begin
          key_valid = 1'b1;
          key_code  = KeyMap[{page_q, row_q, col_q}];
          phase_d   = PH_BTN_CHECK;
        end
      end
      default: begin
        // Button check; unused phase codes land here as well
        if (btn_low) begin
          wait_d  = debounce_q;
          phase_d = PH_BTN_DEBOUNCE;
        end else begin
          start_row = 1'b1;
        end
      end
    endcase

    if (scan) begin
      if (hit.found) begin
        col_d   = hit.idx;
        wait_d  = debounce_q;
        phase_d = PH_KEY_DEBOUNCE;
      end else if (row_q == RowW'(RowCount - 1)) begin
        phase_d = PH_BTN_CHECK;
      end else begin
        start_row = 1'b1;
        start_idx = row_q + 1'b1;
      end
    end

    // Drive the chosen row low; the row last driven stays low through the button check
    if (start_row) begin
      row_d     = start_idx;
      pattern_d = ~(RowCount'(1) << start_idx);
      col_d     = '0;
      wait_d    = settle_q;
      phase_d   = PH_SETTLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BTN_CHECK;
      row_q     <= '0;
      col_q     <= '0;
      wait_q    <= '0;
      page_q    <= 1'b0;
      pattern_q <= '1;
    end else if (accept) begin
      phase_q   <= phase_d;
      row_q     <= row_d;
      col_q     <= col_d;
      wait_q    <= wait_d;
      page_q    <= page_d;
      pattern_q <= pattern_d;
    end
  end

  // Result carries the values after this tick's update
  always_comb begin
    result.row_drive = pattern_d;
    result.key_valid = key_valid;
    result.key_code  = key_code;
    result.page_led  = page_d;
  end

  kps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/kps_checker.sv
`timescale 1ns / 1ps

module kps_checker
  import kps_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input kps_out_t out_data_o
);

  // A reported key always carries a nonzero code; every keymap entry is printable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_valid |-> out_data_o.key_code != '0)
    else $error("key reported with empty code");

  // No key, no code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.key_valid |-> out_data_o.key_code == '0)
    else $error("code present without key");

  // Never more than one row driven low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(~out_data_o.row_drive))
    else $error("several rows driven at once");

  // A key is reported only while a row is driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_valid |-> $onehot(~out_data_o.row_drive))
    else $error("key reported with no row driven");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result withdrawn or changed");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (.*);
